>>> rtl/wsf_pkg.sv
`default_nettype none

package wsf_pkg;

    // pixel layout, red in the lowest byte
    localparam int CHAN_W    = 8;
    localparam int CHANNELS  = 4;
    localparam int COLORS    = 3;
    localparam int ROWS      = 3;
    localparam int CH_RED    = 0;
    localparam int CH_GREEN  = 1;
    localparam int CH_BLUE   = 2;
    localparam int CH_ALPHA  = 3;

    // arithmetic widths
    localparam int CW_W      = 14;
    localparam int NW_W      = 13;
    localparam int NSUM_W    = 11;
    localparam int Q_BITS    = 12;
    localparam int CPROD_W   = CW_W + CHAN_W + 1;
    localparam int NPROD_W   = NW_W + NSUM_W;
    localparam int SUM_W     = NPROD_W + 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_SIZE_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE        = 3'd0,
        REG_ALPHA_PRESENT = 3'd1,
        REG_FRAME_WIDTH   = 3'd2,
        REG_FRAME_HEIGHT  = 3'd3,
        REG_CENTER_WEIGHT = 3'd4,
        REG_NEIGHBOR_WGT  = 3'd5
    } reg_index_t;

    localparam logic [CFG_SIZE_W-1:0] RST_FRAME_SIZE    = 12'd2048;
    localparam logic [CW_W-1:0]       RST_CENTER_WEIGHT = 14'd4096;

    // geometry defaults
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int OUT_COORD_W    = 11;

    // result queue, depth a power of two
    localparam int FIFO_DEPTH = 8;

    typedef logic [CHANNELS-1:0][CHAN_W-1:0] pix_t;
    typedef logic [COLORS-1:0][CHAN_W-1:0]   rgb_t;
    typedef pix_t [ROWS-1:0]                 column_t;

    typedef struct packed {
        pix_t                            center;
        logic [COLORS-1:0][NSUM_W-1:0]   nsum;
    } win_out_t;

    typedef struct packed {
        logic                    has_int;
        logic                    has_bord;
        logic [OUT_COORD_W-1:0]  x;
        logic [OUT_COORD_W-1:0]  y;
        rgb_t                    int_rgb;
        logic [CHAN_W-1:0]       int_alpha;
        pix_t                    bord_px;
    } fifo_entry_t;

    typedef struct packed {
        logic                    last;
        logic [CHAN_W-1:0]       alpha;
        rgb_t                    rgb;
        logic [OUT_COORD_W-1:0]  y;
        logic [OUT_COORD_W-1:0]  x;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/wsf_ram.sv
`default_nettype none

module wsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/wsf_window.sv
`default_nettype none

module wsf_window
    import wsf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     shift_en,
    input  wire column_t  col,
    output win_out_t      win
);

    // two older columns; the newest is consumed by the sums directly
    column_t col1_reg;
    column_t col2_reg;
    logic [COLORS-1:0][NSUM_W-1:0] nsum_next;

    // eight neighbours of the center after this shift
    always_comb
    begin
        for (int ch = 0; ch < COLORS; ch++)
        begin
            nsum_next[ch] = NSUM_W'(col1_reg[0][ch]) + NSUM_W'(col1_reg[1][ch])
                          + NSUM_W'(col1_reg[2][ch]) + NSUM_W'(col2_reg[0][ch])
                          + NSUM_W'(col2_reg[2][ch]) + NSUM_W'(col[0][ch])
                          + NSUM_W'(col[1][ch])      + NSUM_W'(col[2][ch]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col1_reg <= col2_reg;
            col2_reg <= col;
        end
        win.center <= col2_reg[1];
        win.nsum   <= nsum_next;
    end

endmodule

`default_nettype wire

>>> rtl/wsf_mac.sv
`default_nettype none

module wsf_mac
    import wsf_pkg::*;
(
    input  wire logic                    clk,
    input  wire win_out_t                win,
    input  wire logic signed [CW_W-1:0]  center_weight,
    input  wire logic        [NW_W-1:0]  neighbor_weight,
    output rgb_t                         rgb
);

    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1 << (Q_BITS - 1));

    logic signed [CPROD_W-1:0] cprod_reg [COLORS];
    logic        [NPROD_W-1:0] nprod_reg [COLORS];
    logic signed [SUM_W-1:0]   sum [COLORS];

    // weight products, registered
    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < COLORS; ch++)
        begin
            cprod_reg[ch] <= center_weight * $signed({1'b0, win.center[ch]});
            nprod_reg[ch] <= neighbor_weight * win.nsum[ch];
        end
    end

    // round half up, drop fraction, clamp to a byte
    always_comb
    begin
        for (int ch = 0; ch < COLORS; ch++)
        begin
            sum[ch] = SUM_W'(cprod_reg[ch]) + $signed({2'b00, nprod_reg[ch]}) + ROUND;
            priority if (sum[ch][SUM_W-1])
            begin
                rgb[ch] = '0;
            end
            else if (|sum[ch][SUM_W-2:Q_BITS+CHAN_W])
            begin
                rgb[ch] = '1;
            end
            else
            begin
                rgb[ch] = sum[ch][Q_BITS+CHAN_W-1:Q_BITS];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/wsf_out_fifo.sv
`default_nettype none

module wsf_out_fifo
    import wsf_pkg::*;
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire fifo_entry_t                     push_entry,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]      count,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output result_t                              out_res
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    fifo_entry_t entry_reg [FIFO_DEPTH];
    fifo_entry_t head;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             phase_reg;
    logic             show_int;
    logic             fire;
    logic             pop;

    assign head      = entry_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign count     = count_reg;

    // interior result first, then the border one of the same item
    assign show_int = head.has_int && !phase_reg;
    always_comb
    begin
        if (show_int)
        begin
            out_res.x     = head.x - OUT_COORD_W'(1);
            out_res.y     = head.y - OUT_COORD_W'(1);
            out_res.rgb   = head.int_rgb;
            out_res.alpha = head.int_alpha;
            out_res.last  = !head.has_bord;
        end
        else
        begin
            out_res.x     = head.x;
            out_res.y     = head.y;
            out_res.rgb   = {head.bord_px[CH_BLUE], head.bord_px[CH_GREEN],
                             head.bord_px[CH_RED]};
            out_res.alpha = head.bord_px[CH_ALPHA];
            out_res.last  = 1'b1;
        end
    end

    assign fire = out_valid && out_ready;
    assign pop  = fire && out_res.last;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
                phase_reg  <= 1'b0;
            end
            else if (fire)
            begin
                phase_reg <= 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

>>> rtl/weighted_3x3_smoothing_filter_core.sv
`default_nettype none

// Weighted 3x3 smoothing filter for a raster pixel stream. One pixel is
// accepted every clock cycle while s_tready is high; the two line stores are
// single-port-read RAMs read at the pixel's column and written back in the
// following cycle; that read-modify-write per column sustains one pixel per
// cycle. A pixel passes the line read, window and neighbor sums and weight
// products, then is rounded and clamped into the result queue. Results leave
// an eight-entry queue at one per cycle while m_tready is high, so a pixel
// that yields two results (the interior pixel up and left of it plus itself
// on the border) takes two output transfers. Each result carries its column
// and row, and tlast marks the final result caused by an input pixel; pixels
// that cause none produce no output. The line stores are not cleared; they
// are filled by the first two rows of each frame before any interior pixel
// is computed. Configure only while no pixel is in flight; writing the frame
// width or height restarts the frame at the top-left pixel.
module weighted_3x3_smoothing_filter_core
    import wsf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // fields from bit 0: red, green, blue, alpha
    input  wire logic [31:0]            s_tdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // fields from bit 0: out_x, out_y, out_red, out_green, out_blue, out_alpha, zero pad
    output logic [55:0]                 m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic                        m_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int SWX  = (XW + 1 > CFG_SIZE_W) ? XW + 1 : CFG_SIZE_W;
    localparam int SWY  = (YW + 1 > CFG_SIZE_W) ? YW + 1 : CFG_SIZE_W;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int CRD_W = CNT_W + 1;

    // configuration registers
    logic                    enable_reg;
    logic                    alpha_present_reg;
    logic [CFG_SIZE_W-1:0]   frame_width_reg;
    logic [CFG_SIZE_W-1:0]   frame_height_reg;
    logic signed [CW_W-1:0]  center_weight_reg;
    logic [NW_W-1:0]         neighbor_weight_reg;
    logic                    cfg_write;
    logic                    size_write;

    // position of the next pixel
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [XW-1:0] w_last;
    logic [YW-1:0] h_last;
    logic [SWX-1:0] fw_ext;
    logic [SWY-1:0] fh_ext;

    logic accept;
    logic emit_int0;
    logic emit_bord0;

    // line read stage
    logic           s1_valid_reg;
    logic [XW-1:0]  s1_x_reg;
    logic [YW-1:0]  s1_y_reg;
    pix_t           s1_px_reg;
    logic           s1_int_reg;
    logic           s1_bord_reg;
    logic           s1_fwd_reg;
    pix_t           s1_fwd_up_reg;
    pix_t           s1_fwd_mid_reg;
    pix_t           up_rd;
    pix_t           mid_rd;
    pix_t           up_col;
    pix_t           mid_col;
    column_t        new_col;

    // window and product stages
    logic           s2_valid_reg;
    logic [XW-1:0]  s2_x_reg;
    logic [YW-1:0]  s2_y_reg;
    pix_t           s2_px_reg;
    logic           s2_int_reg;
    logic           s2_bord_reg;
    logic           s3_valid_reg;
    logic [XW-1:0]  s3_x_reg;
    logic [YW-1:0]  s3_y_reg;
    pix_t           s3_px_reg;
    pix_t           s3_center_reg;
    logic           s3_int_reg;
    logic           s3_bord_reg;
    win_out_t       win;
    rgb_t           mac_rgb;

    // result queue
    logic                push;
    fifo_entry_t         push_entry;
    logic [CNT_W-1:0]    fifo_count;
    logic [CRD_W-1:0]    credit_used;
    result_t             out_res;

    // effective frame size, out-of-range values clamped
    assign fw_ext = SWX'(frame_width_reg);
    assign fh_ext = SWY'(frame_height_reg);
    always_comb
    begin
        priority if (fw_ext == '0)
        begin
            w_last = '0;
        end
        else if (fw_ext > SWX'(MAX_WIDTH))
        begin
            w_last = XW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = XW'(fw_ext - SWX'(1));
        end
        priority if (fh_ext == '0)
        begin
            h_last = '0;
        end
        else if (fh_ext > SWY'(MAX_HEIGHT))
        begin
            h_last = YW'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = YW'(fh_ext - SWY'(1));
        end
    end

    // configuration writes
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign size_write = cfg_write && ((cfg_index == REG_FRAME_WIDTH) ||
                                      (cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg          <= 1'b0;
            alpha_present_reg   <= 1'b0;
            frame_width_reg     <= RST_FRAME_SIZE;
            frame_height_reg    <= RST_FRAME_SIZE;
            center_weight_reg   <= RST_CENTER_WEIGHT;
            neighbor_weight_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ENABLE:        enable_reg          <= cfg_data[0];
                REG_ALPHA_PRESENT: alpha_present_reg   <= cfg_data[0];
                REG_FRAME_WIDTH:   frame_width_reg     <= cfg_data[CFG_SIZE_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg    <= cfg_data[CFG_SIZE_W-1:0];
                REG_CENTER_WEIGHT: center_weight_reg   <= cfg_data[CW_W-1:0];
                REG_NEIGHBOR_WGT:  neighbor_weight_reg <= cfg_data[NW_W-1:0];
                default:           ;
            endcase
        end
    end

    // accept while every in-flight item still has a queue slot
    assign credit_used = CRD_W'(fifo_count) + CRD_W'(s1_valid_reg) + CRD_W'(s2_valid_reg)
                       + CRD_W'(s3_valid_reg);
    assign s_tready    = (credit_used < CRD_W'(FIFO_DEPTH));
    assign accept      = s_tvalid && s_tready;

    assign emit_int0  = (row_reg >= YW'(2)) && (col_reg >= XW'(2));
    assign emit_bord0 = (col_reg == '0) || (col_reg == w_last) ||
                        (row_reg == '0) || (row_reg == h_last);

    // raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (size_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + YW'(1);
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    // line stores, read at accept, written back in the next cycle
    wsf_ram #(
        .WIDTH ($bits(pix_t)),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_x_reg),
        .wr_data (mid_col),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (up_rd)
    );

    wsf_ram #(
        .WIDTH ($bits(pix_t)),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_x_reg),
        .wr_data (s1_px_reg),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (mid_rd)
    );

    // take the words being written when the read hit the same column
    assign up_col  = s1_fwd_reg ? s1_fwd_up_reg  : up_rd;
    assign mid_col = s1_fwd_reg ? s1_fwd_mid_reg : mid_rd;
    assign new_col = {s1_px_reg, mid_col, up_col};

    wsf_window u_window (
        .clk      (clk),
        .shift_en (s1_valid_reg),
        .col      (new_col),
        .win      (win)
    );

    wsf_mac u_mac (
        .clk             (clk),
        .win             (win),
        .center_weight   (center_weight_reg),
        .neighbor_weight (neighbor_weight_reg),
        .rgb             (mac_rgb)
    );

    // pipeline valids and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s1_fwd_reg   <= accept && s1_valid_reg && (s1_x_reg == col_reg);
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg       <= col_reg;
            s1_y_reg       <= row_reg;
            s1_px_reg      <= s_tdata;
            s1_int_reg     <= emit_int0;
            s1_bord_reg    <= emit_bord0;
            s1_fwd_up_reg  <= mid_col;
            s1_fwd_mid_reg <= s1_px_reg;
        end
        s2_x_reg      <= s1_x_reg;
        s2_y_reg      <= s1_y_reg;
        s2_px_reg     <= s1_px_reg;
        s2_int_reg    <= s1_int_reg;
        s2_bord_reg   <= s1_bord_reg;
        s3_x_reg      <= s2_x_reg;
        s3_y_reg      <= s2_y_reg;
        s3_px_reg     <= s2_px_reg;
        s3_int_reg    <= s2_int_reg;
        s3_bord_reg   <= s2_bord_reg;
        s3_center_reg <= win.center;
    end

    // queue entry for this item
    always_comb
    begin
        push_entry.has_int   = s3_int_reg;
        push_entry.has_bord  = s3_bord_reg;
        push_entry.x         = OUT_COORD_W'(s3_x_reg);
        push_entry.y         = OUT_COORD_W'(s3_y_reg);
        push_entry.int_rgb   = enable_reg ? mac_rgb
                             : {s3_center_reg[CH_BLUE], s3_center_reg[CH_GREEN],
                                s3_center_reg[CH_RED]};
        push_entry.int_alpha = alpha_present_reg ? s3_center_reg[CH_ALPHA] : '0;
        push_entry.bord_px   = s3_px_reg;
        if (!alpha_present_reg)
        begin
            push_entry.bord_px[CH_ALPHA] = '0;
        end
    end
    assign push = s3_valid_reg && (s3_int_reg || s3_bord_reg);

    wsf_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .count      (fifo_count),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = {2'b00, out_res.alpha, out_res.rgb[CH_BLUE], out_res.rgb[CH_GREEN],
                      out_res.rgb[CH_RED], out_res.y, out_res.x};
    assign m_tlast = out_res.last;

    // queue never receives an item without a reserved slot
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_count < CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // raster position stays inside the configured frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= w_last) && (row_reg <= h_last))
        else $error("raster position outside frame");

    // back-to-back same-column access only happens for one-pixel rows
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fwd_reg |-> (w_last == '0))
        else $error("line store forwarding on a wide row");

    // every accepted item reaches the final stage
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 s3_valid_reg)
        else $error("pipeline lost an item");

endmodule

`default_nettype wire
